### src/sjts_pkg.sv
`default_nettype none

package sjts_pkg;

    localparam int SLOT_W   = 3;
    localparam int REM_W    = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    // op codes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // scheduling modes
    localparam logic MODE_SRT = 1'b0;   // preemptive
    localparam logic MODE_SPN = 1'b1;   // non-preemptive

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RAN    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd3;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [TIME_W-1:0] arr;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   ran_slot;
        logic                finished;
        logic [TIME_W-1:0]   turnaround;
        logic [TIME_W-1:0]   now;
    } result_t;

endpackage

`default_nettype wire

### src/shortest_job_tick_scheduler_unit.sv
// Arrival and tick results are written to the output register, or to the
//   pending register while the output register is occupied.
// Throughput: one transaction at a time; a tick scans the slots (one task-store
//   read per cycle), or reads only the running slot when it is kept.
// Reset (rst_n, async, active low) clears slots' active bits, time, mode and
//   the running task; the task store itself is not cleared.
`default_nettype none

// Shortest-remaining-time / shortest-process-next tick scheduler.
//
// Slot state (remaining time, arrival stamp) sits in a synchronous task store
// with registered read data. Active bits, time counter and the running task
// are flip-flops in the core.
//
// Tick flow: the accept cycle issues the read of slot 0 (or of the running
// slot when it is kept in non-preemptive mode). Each scan cycle compares the
// returned entry with the running best and issues the next read; the cycle
// that compares the last entry also decrements the winner, writes it back and
// forms the result. Ties keep the lower slot since slots are read in order.
// Reads and writes to the store never overlap across transactions: the next
// transaction is accepted only after the write-back edge.
//
// Results land in an output register; a result that finds it occupied waits in
// a pending register and input is stalled until it moves on.
module shortest_job_tick_scheduler_unit
    import sjts_pkg::*;
#(
    parameter int NUM_TASKS = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                op,
    input  wire logic [SLOT_W-1:0]   task_slot,
    input  wire logic [REM_W-1:0]    burst,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_W-1:0]        ran_slot,
    output logic                     finished,
    output logic [TIME_W-1:0]        turnaround,
    output logic [TIME_W-1:0]        now
);

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int CNT_W = $clog2(NUM_TASKS + 1);

    // mode register; the user must write it only while idle (not enforced here)
    logic sched_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_mode_reg <= MODE_SRT;
        end
        else if (cfg_wr_en)
        begin
            sched_mode_reg <= cfg_wr_data;
        end
    end

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    result_t          out_res;

    sjts_task_mem #(
        .DEPTH  (NUM_TASKS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sjts_sched_core #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .sched_mode (sched_mode_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .task_slot  (task_slot),
        .burst      (burst),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // result transaction fields
    assign status     = out_res.status;
    assign ran_slot   = out_res.ran_slot;
    assign finished   = out_res.finished;
    assign turnaround = out_res.turnaround;
    assign now        = out_res.now;

endmodule

`default_nettype wire

### src/sjts_task_mem.sv
`default_nettype none

// Per-slot task store: remaining time and arrival stamp.
// One write port, one read port, registered read data.
module sjts_task_mem
    import sjts_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/sjts_sched_core.sv
`default_nettype none

// Sequencer: arrival handling, slot scan over the task store, update and
// result register.
module sjts_sched_core
    import sjts_pkg::*;
#(
    parameter int NUM_TASKS = 8,
    parameter int IDX_W     = 3,
    parameter int CNT_W     = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sched_mode,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               op,
    input  wire logic [SLOT_W-1:0]  task_slot,
    input  wire logic [REM_W-1:0]   burst,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output result_t                 out_res,
    output logic                    rd_en,
    output logic [IDX_W-1:0]        rd_addr,
    input  wire entry_t             rd_data,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output entry_t                  wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_TASKS);

    logic [1:0]           state_reg, state_next;
    logic [NUM_TASKS-1:0] active_reg, active_next;
    logic [TIME_W-1:0]    clock_reg, clock_next;
    logic [IDX_W-1:0]     run_slot_reg, run_slot_next;
    logic                 run_vld_reg, run_vld_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 out_vld_reg, out_vld_next;

    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [REM_W-1:0]     best_rem_reg, best_rem_next;
    logic [TIME_W-1:0]    best_arr_reg, best_arr_next;
    result_t              pend_reg, pend_next;
    result_t              out_res_reg, out_res_next;

    logic                 out_free;
    logic                 emit;
    result_t              res;
    logic [IDX_W-1:0]     slot_idx;
    logic                 slot_ok;
    logic                 slot_busy;
    logic                 reject;
    logic                 keep;
    logic                 take;
    logic                 pick_vld;
    logic [IDX_W-1:0]     pick_idx;
    logic [REM_W-1:0]     pick_rem;
    logic [TIME_W-1:0]    pick_arr;
    logic [REM_W-1:0]     new_rem;
    logic [TIME_W-1:0]    clock_inc;

    assign out_free  = !out_vld_reg || !out_stall;
    assign slot_idx  = IDX_W'(task_slot);
    assign slot_ok   = (32'(task_slot) < NUM_TASKS);
    assign slot_busy = slot_ok ? active_reg[slot_idx] : 1'b1;
    assign reject    = slot_busy || (burst == '0);
    assign keep      = (sched_mode == MODE_SPN) && run_vld_reg && active_reg[run_slot_reg];

    // compare stage: entry read last cycle against the running best
    assign take     = active_reg[cmp_idx_reg]
                      && (!best_vld_reg || (rd_data.rem < best_rem_reg));
    assign pick_vld = take || best_vld_reg;
    assign pick_idx = take ? cmp_idx_reg : best_idx_reg;
    assign pick_rem = take ? rd_data.rem : best_rem_reg;
    assign pick_arr = take ? rd_data.arr : best_arr_reg;

    assign new_rem   = REM_W'(pick_rem - REM_W'(1));
    assign clock_inc = TIME_W'(clock_reg + TIME_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        clock_next    = clock_reg;
        run_slot_next = run_slot_reg;
        run_vld_next  = run_vld_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        best_rem_next = best_rem_reg;
        best_arr_next = best_arr_reg;
        pend_next     = pend_reg;
        out_res_next  = out_res_reg;
        out_vld_next  = out_vld_reg && out_stall;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        emit          = 1'b0;
        res           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_ARRIVE)
                    begin
                        emit         = 1'b1;
                        res.status   = reject ? ST_REJECT : ST_ACCEPT;
                        res.ran_slot = task_slot;
                        res.now      = clock_reg;
                        if (!reject)
                        begin
                            wr_en                 = 1'b1;
                            wr_addr               = slot_idx;
                            wr_data.rem           = burst;
                            wr_data.arr           = clock_reg;
                            active_next[slot_idx] = 1'b1;
                        end
                    end
                    else
                    begin
                        best_vld_next = 1'b0;
                        state_next    = S_SCAN;
                        rd_en         = 1'b1;
                        if (keep)
                        begin
                            // only the running slot is looked at
                            rd_addr       = run_slot_reg;
                            cmp_idx_next  = run_slot_reg;
                            scan_cnt_next = SCAN_END;
                        end
                        else
                        begin
                            rd_addr       = '0;
                            cmp_idx_next  = '0;
                            scan_cnt_next = CNT_W'(1);
                        end
                    end
                end
            end

            S_SCAN:
            begin
                best_vld_next = pick_vld;
                best_idx_next = pick_idx;
                best_rem_next = pick_rem;
                best_arr_next = pick_arr;
                if (scan_cnt_reg != SCAN_END)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_cnt_reg[IDX_W-1:0];
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = CNT_W'(scan_cnt_reg + CNT_W'(1));
                end
                else
                begin
                    emit       = 1'b1;
                    clock_next = clock_inc;
                    res.now    = clock_inc;
                    if (pick_vld)
                    begin
                        res.status   = ST_RAN;
                        res.ran_slot = SLOT_W'(pick_idx);
                        wr_en        = 1'b1;
                        wr_addr      = pick_idx;
                        wr_data.rem  = new_rem;
                        wr_data.arr  = pick_arr;
                        if (new_rem == '0)
                        begin
                            active_next[pick_idx] = 1'b0;
                            res.finished          = 1'b1;
                            res.turnaround        = TIME_W'(clock_inc - pick_arr);
                            run_vld_next          = 1'b0;
                        end
                        else
                        begin
                            run_slot_next = pick_idx;
                            run_vld_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        res.status   = ST_IDLE;
                        run_vld_next = 1'b0;
                    end
                end
            end

            S_PUSH:
            begin
                if (out_free)
                begin
                    out_res_next = pend_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // finished result goes straight to the output register when it is free
        if (emit)
        begin
            if (out_free)
            begin
                out_res_next = res;
                out_vld_next = 1'b1;
                state_next   = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_PUSH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            clock_reg    <= '0;
            run_slot_reg <= '0;
            run_vld_reg  <= 1'b0;
            scan_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            clock_reg    <= clock_next;
            run_slot_reg <= run_slot_next;
            run_vld_reg  <= run_vld_next;
            scan_cnt_reg <= scan_cnt_next;
            out_vld_reg  <= out_vld_next;
            best_vld_reg <= best_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_arr_reg <= best_arr_next;
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

`ifndef SYNTHESIS
    a_run_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        run_vld_reg |-> active_reg[run_slot_reg])
        else $error("running slot not active");

    a_best_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && best_vld_reg) |-> active_reg[best_idx_reg])
        else $error("scan best slot not active");

    a_clock_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (clock_reg != $past(clock_reg)) |-> ($past(state_reg) == S_SCAN))
        else $error("time advanced outside tick update");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_IDLE && in_valid && op == OP_ARRIVE)
                   || (state_reg == S_SCAN && scan_cnt_reg == SCAN_END)))
        else $error("unexpected task store write");
`endif

endmodule

`default_nettype wire
